FILE: hdl/tbf_pkg.sv
// Package for the token Bloom filter core: hash constants, default sizes,
// the control state type and small helper functions.
// Depends on nothing; used by token_bloom_filter_core.
package tbf_pkg;

  // MurmurHash3_x86_32 constants.
  localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2 = 32'h1b873593;
  localparam logic [31:0] MM_N  = 32'he6546b64;
  localparam logic [31:0] MM_F1 = 32'h85ebca6b;
  localparam logic [31:0] MM_F2 = 32'hc2b2ae35;

  // Default sizes.
  localparam int FILTER_SIZE_DEF = 1048576;
  localparam int MAX_HASHES_DEF  = 8;

  // Filter bits held in one memory row.
  localparam int ROW_BITS = 64;
  localparam int COL_W    = 6;

  // Input command codes.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_CHECK  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Hash count register reset value.
  localparam logic [3:0] HASH_COUNT_RST = 4'd8;

  // Control sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_BLK1,
    S_BLK2,
    S_BLK3,
    S_CLOSE,
    S_TAIL1,
    S_TAIL2,
    S_TAIL3,
    S_MIX1,
    S_MIX2,
    S_MIX3,
    S_MOD,
    S_READ,
    S_RMW,
    S_EMIT
  } tbf_state_t;

  // Left rotate of a 32-bit word.
  function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
    rotl32 = (x << r) | (x >> (32 - r));
  endfunction

endpackage

FILE: hdl/token_bloom_filter_core.sv
// Top level of the token Bloom filter core: tokenizer, streaming murmur3
// hashes, modulo unit and the filter bit memory. Depends on tbf_pkg.
//
// Usage: text words enter on the input channel (cmd, text_byte, last with
// in_valid/in_ready). Letters are folded to lower case and runs of letters
// and digits form tokens. cmd selects insert, check or clear. A token closed
// in check mode yields one word on the output channel (token_present with
// out_valid/out_ready); insert and clear yield nothing. The user must set
// hash_count at APB address 0 while the core is idle; nothing enforces it.
// Steps: a byte that fills a 4-byte block goes through states BLK1 to BLK3,
// where the shared 32x32 multiplier scrambles the block. Closing a token
// passes the close state, then TAIL1 to TAIL3 when a partial block remains,
// then for each probed hash the fmix steps MIX1 to MIX3, the modulo unit,
// which estimates the quotient with a reciprocal multiply, multiplies back
// and corrects once, and the read-modify-write of the filter row memory.
// A check then hands its word to the output register in the emit state.
// Reset and clear: the filter memory is swept to zero one 64-bit row per
// cycle, ceil(FILTER_SIZE/64) rows (16384 at the default size); no word is
// accepted during the sweep. A stalled output holds its word; the core keeps
// accepting input and waits only when a second check result is ready.
module token_bloom_filter_core
  import tbf_pkg::*;
#(
  parameter int FILTER_SIZE = FILTER_SIZE_DEF,
  parameter int MAX_HASHES  = MAX_HASHES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  text_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        token_present,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int ROWS   = (FILTER_SIZE + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W  = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
  localparam int CNT_W  = $clog2(MAX_HASHES + 1);
  localparam int P_SH   = $clog2(FILTER_SIZE) - 1;
  localparam logic [63:0] RECIP_W = (64'd1 << (32 + P_SH)) / 64'(FILTER_SIZE);
  localparam logic [31:0] RECIP   = RECIP_W[31:0];
  localparam logic [31:0] MODULUS = 32'(FILTER_SIZE);
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

  // Filter memory.
  logic [ROW_BITS-1:0] mem [ROWS];
  logic [ROW_BITS-1:0] rd;
  logic                mem_we;
  logic [ROW_AW-1:0]   mem_waddr;
  logic [ROW_BITS-1:0] mem_wdata;

  // Control and token state.
  tbf_state_t state, state_next;
  logic [3:0]        hash_count;
  logic [31:0]       running_hash [MAX_HASHES];
  logic [31:0]       partial_block;
  logic [1:0]        block_fill;
  logic [31:0]       token_length;
  logic              token_open;
  logic              close_pending;
  logic              close_insert;
  logic [ROW_AW-1:0] clr_row;
  logic [IDX_W-1:0]  idx;
  logic              present;
  logic [31:0]       tail_k;
  logic [31:0]       mul_p;
  logic [31:0]       hreg;
  logic [31:0]       quot;
  logic [31:0]       rem;
  logic [1:0]        mod_cnt;
  logic [ROW_AW-1:0] row_q;
  logic [COL_W-1:0]  col_q;

  // Combinational helpers.
  logic              accept;
  logic [7:0]        folded;
  logic              alnum;
  logic [31:0]       mul_a, mul_b, mul_out;
  logic [31:0]       mix_h0, mix_h1;
  logic [63:0]       recip_prod;
  logic [31:0]       rem_fix;
  logic [CNT_W-1:0]  eff_count;
  logic              last_hash;
  logic              probe_bit;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == 1'b0) ? {28'd0, hash_count} : 32'd0;

  // Case folding and character class.
  always_comb begin
    folded = text_byte;
    if (text_byte >= 8'h41 && text_byte <= 8'h5a) begin
      folded = text_byte + 8'h20;
    end
    alnum = (folded >= 8'h61 && folded <= 8'h7a) || (folded >= 8'h30 && folded <= 8'h39);
  end

  // Number of hashes actually probed.
  always_comb begin
    if (hash_count == 4'd0) begin
      eff_count = CNT_W'(1);
    end else if (32'(hash_count) > MAX_HASHES) begin
      eff_count = CNT_W'(MAX_HASHES);
    end else begin
      eff_count = CNT_W'(hash_count);
    end
    last_hash = (CNT_W'(idx) + CNT_W'(1)) == eff_count;
  end

  // Shared multiplier operand selection.
  always_comb begin
    mix_h0 = running_hash[idx] ^ tail_k ^ token_length;
    mix_h1 = mix_h0 ^ (mix_h0 >> 16);
    mul_a  = partial_block;
    mul_b  = MM_C1;
    unique case (state)
      S_BLK2, S_TAIL2: begin
        mul_a = rotl32(mul_p, 15);
        mul_b = MM_C2;
      end
      S_MIX1: begin
        mul_a = mix_h1;
        mul_b = MM_F1;
      end
      S_MIX2: begin
        mul_a = mul_p ^ (mul_p >> 13);
        mul_b = MM_F2;
      end
      default: begin
        mul_a = partial_block;
        mul_b = MM_C1;
      end
    endcase
    mul_out = mul_a * mul_b;
  end

  // Quotient estimate by reciprocal multiply; it is exact or one too small,
  // so a single compare and subtract finishes the remainder.
  always_comb begin
    recip_prod = {32'd0, hreg} * {32'd0, RECIP};
    rem_fix    = (rem >= MODULUS) ? rem - MODULUS : rem;
  end

  assign probe_bit = rd[col_q];

  // Memory write selection: clearing sweep or bit set.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = row_q;
    mem_wdata = rd | (ROW_BITS'(1) << col_q);
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_row;
      mem_wdata = '0;
    end else if (state == S_RMW && close_insert) begin
      mem_we = 1'b1;
    end
  end

  // Filter memory ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd <= mem[row_q];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_row == LAST_ROW) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (cmd == CMD_CLEAR) begin
            state_next = S_CLEAR;
          end else if (cmd == CMD_INSERT || cmd == CMD_CHECK) begin
            if (alnum) begin
              if (block_fill == 2'd3) begin
                state_next = S_BLK1;
              end else if (last) begin
                state_next = S_CLOSE;
              end
            end else if (token_open) begin
              state_next = S_CLOSE;
            end
          end
        end
      end
      S_BLK1:  state_next = S_BLK2;
      S_BLK2:  state_next = S_BLK3;
      S_BLK3:  state_next = close_pending ? S_CLOSE : S_IDLE;
      S_CLOSE: state_next = (block_fill != 2'd0) ? S_TAIL1 : S_MIX1;
      S_TAIL1: state_next = S_TAIL2;
      S_TAIL2: state_next = S_TAIL3;
      S_TAIL3: state_next = S_MIX1;
      S_MIX1:  state_next = S_MIX2;
      S_MIX2:  state_next = S_MIX3;
      S_MIX3:  state_next = S_MOD;
      S_MOD: begin
        if (mod_cnt == 2'd2) begin
          state_next = S_READ;
        end
      end
      S_READ:  state_next = S_RMW;
      S_RMW: begin
        if (last_hash) begin
          state_next = close_insert ? S_IDLE : S_EMIT;
        end else begin
          state_next = S_MIX1;
        end
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register, configuration and datapath.
  always_ff @(posedge clk) begin
    mul_p <= mul_out;
    if (rst) begin
      state         <= S_CLEAR;
      clr_row       <= '0;
      hash_count    <= HASH_COUNT_RST;
      partial_block <= '0;
      block_fill    <= '0;
      token_length  <= '0;
      token_open    <= 1'b0;
      close_pending <= 1'b0;
      close_insert  <= 1'b0;
      out_valid     <= 1'b0;
      idx           <= '0;
      mod_cnt       <= '0;
      for (int i = 0; i < MAX_HASHES; i++) begin
        running_hash[i] <= 32'(i);
      end
    end else begin
      state <= state_next;

      // Configuration write.
      if (psel && penable && pwrite && paddr[2] == 1'b0) begin
        hash_count <= pwdata[3:0];
      end

      // Output word handshake: load a new flag once the register is free.
      if (state == S_EMIT && (!out_valid || out_ready)) begin
        out_valid     <= 1'b1;
        token_present <= present;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_row <= clr_row + ROW_AW'(1);
        end
        S_IDLE: begin
          if (accept) begin
            close_insert  <= (cmd == CMD_INSERT);
            close_pending <= last;
            if (cmd == CMD_CLEAR) begin
              clr_row       <= '0;
              partial_block <= '0;
              block_fill    <= '0;
              token_length  <= '0;
              token_open    <= 1'b0;
              for (int i = 0; i < MAX_HASHES; i++) begin
                running_hash[i] <= 32'(i);
              end
            end else if ((cmd == CMD_INSERT || cmd == CMD_CHECK) && alnum) begin
              partial_block <= partial_block | (32'(folded) << {block_fill, 3'b000});
              block_fill    <= block_fill + 2'd1;
              token_length  <= token_length + 32'd1;
              token_open    <= 1'b1;
            end
          end
        end
        S_BLK1: begin
          partial_block <= '0;
        end
        S_BLK3: begin
          for (int i = 0; i < MAX_HASHES; i++) begin
            running_hash[i] <= (rotl32(running_hash[i] ^ mul_p, 13) * 32'd5) + MM_N;
          end
        end
        S_CLOSE: begin
          idx     <= '0;
          present <= 1'b1;
          tail_k  <= '0;
        end
        S_TAIL3: begin
          tail_k <= mul_p;
        end
        S_MIX3: begin
          hreg    <= mul_p ^ (mul_p >> 16);
          rem     <= '0;
          mod_cnt <= '0;
        end
        S_MOD: begin
          mod_cnt <= mod_cnt + 2'd1;
          if (mod_cnt == 2'd0) begin
            quot <= recip_prod[63:32] >> P_SH;
          end else if (mod_cnt == 2'd1) begin
            rem <= hreg - quot * MODULUS;
          end else begin
            row_q <= ROW_AW'(rem_fix >> COL_W);
            col_q <= rem_fix[COL_W-1:0];
          end
        end
        S_RMW: begin
          if (!close_insert && !probe_bit) begin
            present <= 1'b0;
          end
          idx <= idx + IDX_W'(1);
          if (last_hash) begin
            partial_block <= '0;
            block_fill    <= '0;
            token_length  <= '0;
            token_open    <= 1'b0;
            for (int i = 0; i < MAX_HASHES; i++) begin
              running_hash[i] <= 32'(i);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
